FILE: rtl/scd_pkg.sv
// Shared types, constants and the helper function of the schedule countdown display.
package scd_pkg;

   typedef logic [4:0]  hour_type;
   typedef logic [5:0]  minute_type;
   typedef logic [5:0]  second_type;
   typedef logic [10:0] bound_min_type;
   typedef logic [16:0] secs_type;
   typedef logic [1:0]  phase_type;

   typedef enum logic [1:0] {
      CSR_SHIFT_START,
      CSR_BREAK_START,
      CSR_BREAK_END,
      CSR_SHIFT_END
   } csr_reg_type;

   localparam int NUM_BOUNDS = 4;

   localparam secs_type SECS_PER_DAY  = 17'd86400;
   localparam secs_type SECS_PER_HOUR = 17'd3600;
   localparam secs_type SECS_PER_MIN  = 17'd60;

   // x / 60 == (x * MIN_RECIP) >> MIN_RECIP_SHIFT for every x below 3600
   localparam int MIN_RECIP       = 17477;
   localparam int MIN_RECIP_SHIFT = 20;

   // start of each whole hour, in seconds
   localparam secs_type HOUR_SECS [24] = '{
      17'd0,     17'd3600,  17'd7200,  17'd10800, 17'd14400, 17'd18000,
      17'd21600, 17'd25200, 17'd28800, 17'd32400, 17'd36000, 17'd39600,
      17'd43200, 17'd46800, 17'd50400, 17'd54000, 17'd57600, 17'd61200,
      17'd64800, 17'd68400, 17'd72000, 17'd75600, 17'd79200, 17'd82800
   };

   // sampled time plus the colon state taken at acceptance
   typedef struct packed {
      hour_type   hour_now;
      minute_type minute_now;
      second_type second_now;
      logic       colon;
   } sample_type;

   typedef struct packed {
      phase_type phase;
      secs_type  seconds_left;
      logic      colon;
   } count_type;

   typedef struct packed {
      logic [1:0] hour_tens;
      logic [3:0] hour_ones;
      logic [2:0] minute_tens;
      logic [3:0] minute_ones;
      logic       blank_leading;
      logic       show_dashes;
      logic       colon_on;
   } disp_type;

   typedef struct packed {
      logic [2:0] tens;
      logic [3:0] ones;
   } dec_type;

   // decimal split of a value below 60
   function automatic dec_type split_dec(input logic [5:0] v);
      dec_type d;
      if (v >= 6'd50) begin
         d.tens = 3'd5;
         d.ones = 4'(v - 6'd50);
      end else if (v >= 6'd40) begin
         d.tens = 3'd4;
         d.ones = 4'(v - 6'd40);
      end else if (v >= 6'd30) begin
         d.tens = 3'd3;
         d.ones = 4'(v - 6'd30);
      end else if (v >= 6'd20) begin
         d.tens = 3'd2;
         d.ones = 4'(v - 6'd20);
      end else if (v >= 6'd10) begin
         d.tens = 3'd1;
         d.ones = 4'(v - 6'd10);
      end else begin
         d.tens = 3'd0;
         d.ones = 4'(v);
      end
      return d;
   endfunction

endpackage

FILE: rtl/scd_req_if.sv
// Input channel: one time-of-day sample per word.
interface scd_req_if;
   import scd_pkg::*;

   logic       valid;
   logic       ready;
   hour_type   hour_now;
   minute_type minute_now;
   second_type second_now;

   modport source (output valid, hour_now, minute_now, second_now, input ready);
   modport sink   (input valid, hour_now, minute_now, second_now, output ready);
endinterface

FILE: rtl/scd_rsp_if.sv
// Result channel: phase, remaining time and display digits per word.
interface scd_rsp_if;
   import scd_pkg::*;

   logic       valid;
   logic       ready;
   phase_type  phase;
   secs_type   seconds_left;
   logic [1:0] hour_tens;
   logic [3:0] hour_ones;
   logic [2:0] minute_tens;
   logic [3:0] minute_ones;
   logic       blank_leading;
   logic       show_dashes;
   logic       colon_on;

   modport source (output valid, phase, seconds_left, hour_tens, hour_ones, minute_tens,
                   minute_ones, blank_leading, show_dashes, colon_on, input ready);
   modport sink   (input valid, phase, seconds_left, hour_tens, hour_ones, minute_tens,
                   minute_ones, blank_leading, show_dashes, colon_on, output ready);
endinterface

FILE: rtl/scd_phase.sv
// Phase lookup: time of day against the four schedule boundaries.
module scd_phase (
   input  scd_pkg::sample_type smp,
   input  scd_pkg::secs_type   bound_sec [scd_pkg::NUM_BOUNDS],
   output scd_pkg::count_type  cnt
);
   import scd_pkg::*;

   secs_type  tod;
   phase_type ph;

   always_comb begin
      tod = 17'(smp.hour_now) * SECS_PER_HOUR + 17'(smp.minute_now) * SECS_PER_MIN
          + 17'(smp.second_now);
      ph = '0;
      // later phases override earlier ones
      for (int k = 1; k < NUM_BOUNDS; k++) begin
         if (tod >= bound_sec[k-1] && tod < bound_sec[k]) begin
            ph = 2'(k);
         end
      end
      cnt.phase        = ph;
      cnt.seconds_left = (ph != '0) ? bound_sec[ph] - tod : '0;
      cnt.colon        = smp.colon;
   end

endmodule

FILE: rtl/scd_digits.sv
// Remaining time to hour/minute digits and display flags.
module scd_digits (
   input  scd_pkg::count_type cnt,
   output scd_pkg::disp_type  disp
);
   import scd_pkg::*;

   secs_type    rem;
   logic [22:0] over;
   logic [4:0]  hrs;
   logic [11:0] sub;
   logic [26:0] prod;
   logic [5:0]  mins;
   dec_type     hdec;
   dec_type     mdec;

   always_comb begin
      // remainder never reaches two days, one subtract suffices
      rem = (cnt.seconds_left >= SECS_PER_DAY) ? cnt.seconds_left - SECS_PER_DAY
                                                : cnt.seconds_left;
      for (int k = 1; k < 24; k++) begin
         over[k-1] = (rem >= HOUR_SECS[k]);
      end
      hrs  = 5'($countones(over));
      sub  = 12'(rem - HOUR_SECS[hrs]);
      prod = 27'(sub) * 27'(MIN_RECIP);
      mins = prod[MIN_RECIP_SHIFT +: 6];
      hdec = split_dec({1'b0, hrs});
      mdec = split_dec(mins);

      disp = '0;
      if (cnt.seconds_left != '0) begin
         disp.hour_tens     = 2'(hdec.tens);
         disp.hour_ones     = hdec.ones;
         disp.minute_tens   = mdec.tens;
         disp.minute_ones   = mdec.ones;
         disp.blank_leading = (hrs < 5'd10);
         disp.colon_on      = cnt.colon;
      end else begin
         disp.show_dashes = 1'b1;
      end
   end

endmodule

FILE: rtl/schedule_countdown_display.sv
// Top level of the schedule countdown display.
//
// req_chan carries one time-of-day sample per word (hour, minute, second).
// rsp_chan returns one word per sample, in order: the schedule phase, the
// seconds left to the end of that phase, the same time as hour and minute
// digits, and the display flags (leading blank, dashes, colon).
// csr_we/csr_index/csr_wdata write the four boundary minutes; each is kept
// as seconds of the day. Write them only while no word is in flight.
//
// Three register stages: sample register, phase/count register, result
// register. An accepted word moves from the sample register through the
// phase/count register into the result register, which drives rsp_chan
// valid; while rsp_chan does not stall, one word per cycle is sustained.
// The colon flag flips on every accepted word.
// When rsp_chan stalls, words pile into the empty stages behind it; req_chan
// ready drops only once all three stages hold a word.
// Synchronous reset empties the pipe, clears the boundaries to minute zero
// and the colon to off.
module schedule_countdown_display (
   input  logic                 clock,
   input  logic                 reset,
   scd_req_if.sink              req_chan,
   scd_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  scd_pkg::csr_reg_type csr_index,
   input  scd_pkg::bound_min_type csr_wdata
);
   import scd_pkg::*;

   // boundary registers, in seconds of the day
   secs_type   bound_sec_ff [NUM_BOUNDS];
   secs_type   bound_wr;

   // pipeline control
   logic       s1_valid_ff, s1_valid_in;
   logic       s2_valid_ff, s2_valid_in;
   logic       s3_valid_ff, s3_valid_in;
   logic       load1, load2, load3;
   logic       accept;

   logic       colon_ff, colon_in;

   // payload
   sample_type smp_ff, smp_in;
   count_type  cnt_ff;
   count_type  cnt_in;
   disp_type   disp_in;
   disp_type   disp_ff;

   // each stage moves when the one after it can take a word
   assign load3  = !s3_valid_ff || rsp_chan.ready;
   assign load2  = !s2_valid_ff || load3;
   assign load1  = !s1_valid_ff || load2;
   assign accept = req_chan.valid && load1;

   assign req_chan.ready = load1;

   always_comb begin
      s1_valid_in = load1 ? req_chan.valid : s1_valid_ff;
      s2_valid_in = load2 ? s1_valid_ff    : s2_valid_ff;
      s3_valid_in = load3 ? s2_valid_ff    : s3_valid_ff;
      colon_in    = accept ? !colon_ff : colon_ff;

      smp_in.hour_now   = req_chan.hour_now;
      smp_in.minute_now = req_chan.minute_now;
      smp_in.second_now = req_chan.second_now;
      smp_in.colon      = !colon_ff;   // colon state after this word's toggle
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         colon_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         colon_ff    <= colon_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         smp_ff <= smp_in;
      end
      if (load2) begin
         cnt_ff <= cnt_in;
      end
      if (load3) begin
         disp_ff <= disp_in;
      end
   end

   // boundary writes, minutes scaled to seconds on the way in
   assign bound_wr = 17'(csr_wdata) * SECS_PER_MIN;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_BOUNDS; k++) begin
            bound_sec_ff[k] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHIFT_START: bound_sec_ff[0] <= bound_wr;
            CSR_BREAK_START: bound_sec_ff[1] <= bound_wr;
            CSR_BREAK_END:   bound_sec_ff[2] <= bound_wr;
            CSR_SHIFT_END:   bound_sec_ff[3] <= bound_wr;
            default: ;
         endcase
      end
   end

   scd_phase u_phase (
      .smp       (smp_ff),
      .bound_sec (bound_sec_ff),
      .cnt       (cnt_in)
   );

   scd_digits u_digits (
      .cnt  (cnt_ff),
      .disp (disp_in)
   );

   // stage-three copy of phase and count rides alongside the digits
   phase_type phase_ff;
   secs_type  left_ff;

   always_ff @(posedge clock) begin
      if (load3) begin
         phase_ff <= cnt_ff.phase;
         left_ff  <= cnt_ff.seconds_left;
      end
   end

   assign rsp_chan.valid         = s3_valid_ff;
   assign rsp_chan.phase         = phase_ff;
   assign rsp_chan.seconds_left  = left_ff;
   assign rsp_chan.hour_tens     = disp_ff.hour_tens;
   assign rsp_chan.hour_ones     = disp_ff.hour_ones;
   assign rsp_chan.minute_tens   = disp_ff.minute_tens;
   assign rsp_chan.minute_ones   = disp_ff.minute_ones;
   assign rsp_chan.blank_leading = disp_ff.blank_leading;
   assign rsp_chan.show_dashes   = disp_ff.show_dashes;
   assign rsp_chan.colon_on      = disp_ff.colon_on;

   // dashes exactly when nothing is left, and then no digits and no colon
   a_dash_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.show_dashes |->
         rsp_chan.seconds_left == '0 && rsp_chan.hour_tens == '0 &&
         rsp_chan.hour_ones == '0 && rsp_chan.minute_tens == '0 &&
         rsp_chan.minute_ones == '0 && !rsp_chan.colon_on && !rsp_chan.blank_leading)
      else $error("dash word carries digits");

   a_dash_when_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.seconds_left == '0 |-> rsp_chan.show_dashes)
      else $error("zero count without dashes");

   a_no_phase_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.phase == '0 |-> rsp_chan.seconds_left == '0)
      else $error("count outside all phases");

   a_colon_toggle: assert property (@(posedge clock) disable iff (reset)
      accept && !reset |=> colon_ff != $past(colon_ff))
      else $error("colon did not flip on accepted word");

endmodule

FILE: test/tb_top.sv
// Testbench of the schedule countdown display: prediction, stimulus and result checks.
`timescale 1ns / 100ps

module tb_top;
   import scd_pkg::*;

   // one time-of-day sample as offered on req_chan
   typedef struct packed {
      hour_type   hour_now;
      minute_type minute_now;
      second_type second_now;
   } clock_sample_type;

   // one result word as seen on rsp_chan
   typedef struct packed {
      phase_type  phase;
      secs_type   seconds_left;
      logic [1:0] hour_tens;
      logic [3:0] hour_ones;
      logic [2:0] minute_tens;
      logic [3:0] minute_ones;
      logic       blank_leading;
      logic       show_dashes;
      logic       colon_on;
   } countdown_word_type;

   // Keeps its own copy of the boundaries and the colon, works out the word
   // each accepted sample must produce, and checks words in arrival order.
   class schedule_tracker;
      bound_min_type      bound [NUM_BOUNDS];
      logic               colon;
      countdown_word_type due_words [$];
      int unsigned        errors;
      int unsigned        samples;
      int unsigned        dash_words;
      int unsigned        day_wraps;
      int unsigned        phase_hits [4];

      function new();
         foreach (bound[k]) bound[k] = '0;
         foreach (phase_hits[k]) phase_hits[k] = 0;
         colon      = 1'b0;
         errors     = 0;
         samples    = 0;
         dash_words = 0;
         day_wraps  = 0;
      endfunction

      function void set_bounds(bound_min_type a, bound_min_type b, bound_min_type c,
                               bound_min_type d);
         bound[CSR_SHIFT_START] = a;
         bound[CSR_BREAK_START] = b;
         bound[CSR_BREAK_END]   = c;
         bound[CSR_SHIFT_END]   = d;
      endfunction

      function countdown_word_type countdown_for(clock_sample_type smp);
         secs_type           t, left, rem;
         secs_type           mark [NUM_BOUNDS];
         phase_type          ph;
         int unsigned        hrs, mins;
         int                 k;
         countdown_word_type w;
         t = secs_type'(smp.hour_now) * SECS_PER_HOUR
           + secs_type'(smp.minute_now) * SECS_PER_MIN
           + secs_type'(smp.second_now);
         foreach (mark[i]) mark[i] = secs_type'(bound[i]) * SECS_PER_MIN;
         // later intervals override earlier ones
         ph = '0;
         for (k = 1; k < NUM_BOUNDS; k++)
            if (t >= mark[k-1] && t < mark[k]) ph = phase_type'(k);
         left = (ph != '0) ? mark[ph] - t : '0;
         w = '0;
         w.phase        = ph;
         w.seconds_left = left;
         if (left != '0) begin
            rem  = left % SECS_PER_DAY;
            hrs  = int'(rem / SECS_PER_HOUR);
            mins = (int'(rem) - hrs * int'(SECS_PER_HOUR)) / int'(SECS_PER_MIN);
            w.hour_tens     = 2'(hrs / 10);
            w.hour_ones     = 4'(hrs % 10);
            w.minute_tens   = 3'(mins / 10);
            w.minute_ones   = 4'(mins % 10);
            w.blank_leading = (hrs < 10);
            w.colon_on      = colon;
         end else begin
            w.show_dashes = 1'b1;
         end
         return w;
      endfunction

      function void note_sample(clock_sample_type smp);
         countdown_word_type w;
         colon = ~colon;
         w = countdown_for(smp);
         due_words.push_back(w);
         samples++;
         phase_hits[w.phase]++;
         if (w.show_dashes) dash_words++;
         if (w.seconds_left >= SECS_PER_DAY) day_wraps++;
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(countdown_word_type got);
         countdown_word_type want;
         if (due_words.size() == 0) begin
            $error("result word with no sample outstanding (seconds_left %0d)",
                   got.seconds_left);
            errors++;
            return;
         end
         want = due_words.pop_front();
         check_field("phase",         want.phase,         got.phase);
         check_field("seconds_left",  want.seconds_left,  got.seconds_left);
         check_field("hour_tens",     want.hour_tens,     got.hour_tens);
         check_field("hour_ones",     want.hour_ones,     got.hour_ones);
         check_field("minute_tens",   want.minute_tens,   got.minute_tens);
         check_field("minute_ones",   want.minute_ones,   got.minute_ones);
         check_field("blank_leading", want.blank_leading, got.blank_leading);
         check_field("show_dashes",   want.show_dashes,   got.show_dashes);
         check_field("colon_on",      want.colon_on,      got.colon_on);
      endfunction

      function int unsigned pending();
         return due_words.size();
      endfunction
   endclass

   // receiver hold-off used to fill the pipe and back up req_chan
   localparam int unsigned HOLD_CYCLES = 150;
   // idle cycles after the last result, so a stray extra word would be seen
   localparam int unsigned TAIL_CYCLES = 8;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_we;
   csr_reg_type   csr_index;
   bound_min_type csr_wdata;

   scd_req_if req_bus ();
   scd_rsp_if rsp_bus ();

   schedule_tracker sb;
   bit              hold_request = 1'b0;
   int unsigned     schedules = 0;

   schedule_countdown_display dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Offer one word and hold it until the block takes it. Valid stays high
   // on return, so back-to-back calls give a gapless burst.
   task automatic send_word(clock_sample_type smp);
      req_bus.valid      <= 1'b1;
      req_bus.hour_now   <= smp.hour_now;
      req_bus.minute_now <= smp.minute_now;
      req_bus.second_now <= smp.second_now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_sample(smp);
   endtask

   task automatic send_time(hour_type h, minute_type m, second_type s);
      clock_sample_type smp;
      smp.hour_now   = h;
      smp.minute_now = m;
      smp.second_now = s;
      send_word(smp);
   endtask

   // stop offering and let every outstanding word come back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // boundaries only change with the pipe empty; one write per cycle
   task automatic program_schedule(bound_min_type a, bound_min_type b, bound_min_type c,
                                   bound_min_type d);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_SHIFT_START;
      csr_wdata <= a;
      @(posedge clock);
      csr_index <= CSR_BREAK_START;
      csr_wdata <= b;
      @(posedge clock);
      csr_index <= CSR_BREAK_END;
      csr_wdata <= c;
      @(posedge clock);
      csr_index <= CSR_SHIFT_END;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_bounds(a, b, c, d);
      schedules++;
   endtask

   // ordered schedule, arbitrary in-range schedule, or full 11-bit values
   task automatic random_schedule();
      bound_min_type bq [$];
      int unsigned   kind;
      kind = $urandom_range(0, 2);
      repeat (NUM_BOUNDS) begin
         if (kind == 2) bq.push_back(bound_min_type'($urandom_range(0, 2047)));
         else           bq.push_back(bound_min_type'($urandom_range(0, 1439)));
      end
      if (kind == 0) bq.sort();
      program_schedule(bq[0], bq[1], bq[2], bq[3]);
   endtask

   // Sample mix: near a boundary (phase edges and one-second remainders),
   // plain in-range times, raw field values, and field corners.
   function automatic clock_sample_type pick_sample();
      clock_sample_type smp;
      int unsigned      sel, x;
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         x = int'(sb.bound[$urandom_range(0, NUM_BOUNDS - 1)]) * 60 + $urandom_range(0, 4);
         x = (x >= 2) ? x - 2 : x;
         smp.hour_now   = hour_type'(x / 3600);
         smp.minute_now = minute_type'((x % 3600) / 60);
         smp.second_now = second_type'(x % 60);
      end else if (sel < 8) begin
         smp.hour_now   = hour_type'($urandom_range(0, 23));
         smp.minute_now = minute_type'($urandom_range(0, 59));
         smp.second_now = second_type'($urandom_range(0, 59));
      end else if (sel == 8) begin
         smp.hour_now   = hour_type'($urandom);
         smp.minute_now = minute_type'($urandom);
         smp.second_now = second_type'($urandom);
      end else begin
         case ($urandom_range(0, 2))
            0:       smp.hour_now = 5'd0;
            1:       smp.hour_now = 5'd23;
            default: smp.hour_now = 5'd31;
         endcase
         case ($urandom_range(0, 2))
            0:       smp.minute_now = 6'd0;
            1:       smp.minute_now = 6'd59;
            default: smp.minute_now = 6'd63;
         endcase
         case ($urandom_range(0, 2))
            0:       smp.second_now = 6'd0;
            1:       smp.second_now = 6'd59;
            default: smp.second_now = 6'd63;
         endcase
      end
      return smp;
   endfunction

   // Bursts of random length with random gaps. With squeeze set, the
   // receiver is asked to hold off while a gapless burst keeps coming,
   // so all three stages fill and req ready drops.
   task automatic run_random(int unsigned count, bit squeeze);
      int unsigned      left_items, burst, gap;
      clock_sample_type smp;
      left_items = count;
      if (squeeze) begin
         hold_request = 1'b1;
         repeat (40) begin
            smp = pick_sample();
            send_word(smp);
         end
         left_items -= 40;
      end
      while (left_items > 0) begin
         burst = $urandom_range(1, 40);
         if (burst > left_items) burst = left_items;
         repeat (burst) begin
            smp = pick_sample();
            send_word(smp);
         end
         left_items -= burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      int p;
      sb = new();
      req_bus.valid      <= 1'b0;
      req_bus.hour_now   <= '0;
      req_bus.minute_now <= '0;
      req_bus.second_now <= '0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_SHIFT_START;
      csr_wdata          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset boundaries: every interval empty, dashes only
      send_time(5'd0, 6'd0, 6'd0);
      send_time(5'd31, 6'd63, 6'd63);

      // working-day schedule 08:00 / 12:00 / 13:00 / 17:00
      program_schedule(11'd480, 11'd720, 11'd780, 11'd1020);
      send_time(5'd7, 6'd59, 6'd59);    // just before the shift
      send_time(5'd8, 6'd0, 6'd0);      // phase one starts
      send_time(5'd11, 6'd59, 6'd59);   // one second left
      send_time(5'd12, 6'd0, 6'd0);     // break starts
      send_time(5'd12, 6'd30, 6'd15);
      send_time(5'd12, 6'd59, 6'd59);
      send_time(5'd13, 6'd0, 6'd0);     // phase three starts
      send_time(5'd16, 6'd59, 6'd59);
      send_time(5'd17, 6'd0, 6'd0);     // shift over
      send_time(5'd23, 6'd59, 6'd59);
      send_time(5'd0, 6'd63, 6'd0);     // minute past its range
      send_time(5'd9, 6'd0, 6'd63);     // second past its range

      // last boundary at 23:59: hour tens digit reaches 2
      program_schedule(11'd0, 11'd0, 11'd0, 11'd1439);
      send_time(5'd0, 6'd0, 6'd0);
      send_time(5'd23, 6'd58, 6'd59);
      send_time(5'd23, 6'd59, 6'd0);

      // boundary past the end of day: remainder over a day wraps the hours
      program_schedule(11'd0, 11'd0, 11'd0, 11'd2047);
      send_time(5'd0, 6'd0, 6'd0);
      send_time(5'd31, 6'd63, 6'd63);

      // overlapping intervals: the later phase wins
      program_schedule(11'd600, 11'd900, 11'd300, 11'd1200);
      send_time(5'd10, 6'd0, 6'd0);
      send_time(5'd5, 6'd0, 6'd0);

      // random part, one schedule per pass
      for (p = 0; p < 8; p++) begin
         case (p)
            0:       program_schedule(11'd480, 11'd720, 11'd780, 11'd1020);
            1:       program_schedule(11'd0, 11'd1, 11'd1438, 11'd1439);
            2:       program_schedule(11'd0, 11'd0, 11'd0, 11'd2047);
            4:       program_schedule(11'd2047, 11'd2047, 11'd2047, 11'd2047);
            default: random_schedule();
         endcase
         run_random(130, p == 3);
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d samples over %0d schedules; phase 0/1/2/3 seen %0d/%0d/%0d/%0d",
               sb.samples, schedules, sb.phase_hits[0], sb.phase_hits[1],
               sb.phase_hits[2], sb.phase_hits[3]);
      $display("dash words %0d, remainders of a full day or more %0d",
               sb.dash_words, sb.day_wraps);
      if (sb.errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver side: stall pattern chosen anew after each random span of cycles
   // ---------------------------------------------------------------------
   initial begin : rsp_stall
      int unsigned mode, span, tick;
      tick = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 300);
         repeat (span) begin
            @(posedge clock);
            tick++;
            if (hold_request) begin
               // long hold-off, counted here
               rsp_bus.ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_request = 1'b0;
            end else begin
               case (mode)
                  0:       rsp_bus.ready <= 1'b1;                        // no stalls
                  1:       rsp_bus.ready <= 1'($urandom_range(0, 1));    // coin toss
                  2:       rsp_bus.ready <= (tick % 4 == 0);             // one in four
                  default: rsp_bus.ready <= ($urandom_range(0, 9) == 0); // mostly stalled
               endcase
            end
         end
      end
   end

   // result monitor: check every accepted word
   initial begin : rsp_watch
      countdown_word_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.phase         = rsp_bus.phase;
            got.seconds_left  = rsp_bus.seconds_left;
            got.hour_tens     = rsp_bus.hour_tens;
            got.hour_ones     = rsp_bus.hour_ones;
            got.minute_tens   = rsp_bus.minute_tens;
            got.minute_ones   = rsp_bus.minute_ones;
            got.blank_leading = rsp_bus.blank_leading;
            got.show_dashes   = rsp_bus.show_dashes;
            got.colon_on      = rsp_bus.colon_on;
            sb.check_result(got);
         end
      end
   end

   // run limit, far above the slowest correct run
   initial begin : watchdog
      #5_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
